// ----- rtl/hex_mesh_face_dedup_top_assert.svh -----
// assertion macros for the hex mesh face dedup block
// used by the port checker; expects aclk and aresetn in scope
`ifndef HEX_MESH_FACE_DEDUP_TOP_ASSERT_SVH
`define HEX_MESH_FACE_DEDUP_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define HMFD_ASSERT_IMP(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("hmfd assertion failed");

// next-cycle implication, disabled during reset
`define HMFD_ASSERT_NXT(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("hmfd assertion failed");

// next-cycle implication that also holds across reset
`define HMFD_ASSERT_NXT_ALWAYS(name, pre, post) \
    name: assert property (@(posedge aclk) (pre) |=> (post)) \
        else $error("hmfd assertion failed");

`endif

// ----- rtl/hmfd_pkg.sv -----
// shared types, constants and helpers for the hex mesh face dedup block
// no dependencies
package hmfd_pkg;

    localparam int MAX_CELLS      = 1024;
    localparam int INDEX_BITS     = 20;
    localparam int FACES_PER_CELL = 6;
    localparam int FACE_MAX       = MAX_CELLS * FACES_PER_CELL;
    localparam int FACE_W         = $clog2(FACE_MAX);
    localparam int PTR_W          = FACE_W + 2;
    localparam int CELL_W         = $clog2(MAX_CELLS + 1);
    localparam int KEY_W          = 4 * INDEX_BITS;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_e;

    typedef logic [INDEX_BITS-1:0]      corner_t;
    typedef logic [3:0][INDEX_BITS-1:0] quad_t;

    typedef struct packed {
        quad_t key;    // key[0] is the smallest corner
        quad_t wind;   // corners in table order
    } face_rec_t;

    typedef struct packed {
        logic [1:0] command;
        corner_t    corner_a;
        corner_t    corner_b;
        corner_t    corner_c;
        corner_t    corner_d;
        corner_t    corner_e;
        corner_t    corner_f;
        corner_t    corner_g;
        corner_t    corner_h;
    } in_item_t;

    typedef struct packed {
        corner_t face_p0;
        corner_t face_p1;
        corner_t face_p2;
        corner_t face_p3;
        logic    on_boundary;
        logic    face_valid;
        logic    final_face;
        logic    store_overflow;
    } out_item_t;

    // corner of the cell used at position pos of face slot
    function automatic logic [2:0] table_corner(input logic [2:0] slot,
                                                input logic [1:0] pos);
        logic [11:0] row;
        unique case (slot)
            3'd0:    row = {3'd3, 3'd2, 3'd1, 3'd0};
            3'd1:    row = {3'd6, 3'd7, 3'd4, 3'd5};
            3'd2:    row = {3'd0, 3'd1, 3'd5, 3'd4};
            3'd3:    row = {3'd7, 3'd3, 3'd0, 3'd4};
            3'd4:    row = {3'd2, 3'd3, 3'd7, 3'd6};
            3'd5:    row = {3'd2, 3'd6, 3'd5, 3'd1};
            default: row = '0;
        endcase
        return row[pos*3 +: 3];
    endfunction

    // key as one word, smallest corner most significant
    function automatic logic [KEY_W-1:0] key_word(input quad_t k);
        return {k[0], k[1], k[2], k[3]};
    endfunction

endpackage

// ----- rtl/hmfd_face_gen.sv -----
// builds the winding and the sorted key of one face of a held cell
// depends on hmfd_pkg
module hmfd_face_gen (
    input  hmfd_pkg::in_item_t  cell_item,
    input  logic [2:0]          slot,
    output hmfd_pkg::face_rec_t rec
);
    import hmfd_pkg::*;

    corner_t corners [8];
    quad_t   wind;
    quad_t   s1;
    quad_t   s2;
    quad_t   s3;

    assign corners[0] = cell_item.corner_a;
    assign corners[1] = cell_item.corner_b;
    assign corners[2] = cell_item.corner_c;
    assign corners[3] = cell_item.corner_d;
    assign corners[4] = cell_item.corner_e;
    assign corners[5] = cell_item.corner_f;
    assign corners[6] = cell_item.corner_g;
    assign corners[7] = cell_item.corner_h;

    always_comb begin
        for (int p = 0; p < 4; p++) begin
            wind[p] = corners[table_corner(slot, 2'(p))];
        end
    end

    // five compare-exchanges sort the four corners
    always_comb begin
        s1 = wind;
        if (s1[0] > s1[1]) begin
            s1[0] = wind[1];
            s1[1] = wind[0];
        end
        if (s1[2] > s1[3]) begin
            s1[2] = wind[3];
            s1[3] = wind[2];
        end
        s2 = s1;
        if (s1[0] > s1[2]) begin
            s2[0] = s1[2];
            s2[2] = s1[0];
        end
        if (s1[1] > s1[3]) begin
            s2[1] = s1[3];
            s2[3] = s1[1];
        end
        s3 = s2;
        if (s2[1] > s2[2]) begin
            s3[1] = s2[2];
            s3[2] = s2[1];
        end
    end

    assign rec.key  = s3;
    assign rec.wind = wind;

endmodule

// ----- rtl/hex_mesh_face_dedup_top.sv -----
// Hex mesh face dedup: a load writes one face record (sorted key and winding)
// per cycle for the six faces of the cell. The first read after any load sorts
// all n = 6 * cells faces by a bottom-up merge sort over two ping-pong order
// memories: an index fill, then ceil(log2 n) passes, one compare per output
// element through the single merge comparator. A read then steps to its face
// and on through each duplicate copy of the face (one order read, one face read
// and one compare per step); a read past the end returns an empty item. Clear,
// unused commands and a load into a full store are handled without leaving the
// idle state. Results wait in an output register so the next item can be
// accepted while one is pending.
// depends on hmfd_pkg and hmfd_face_gen
module hex_mesh_face_dedup_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hmfd_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output hmfd_pkg::out_item_t m_item
);
    import hmfd_pkg::*;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [FACE_W-1:0] fidx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_FILL, ST_MSTART, ST_MRD, ST_MKEY, ST_MCMP,
        ST_WSTART, ST_WORD, ST_WFACE, ST_WHEAD, ST_WNEXT, ST_WNFACE, ST_WNCMP,
        ST_OUT
    } state_t;

    // memories
    face_rec_t face_mem  [FACE_MAX];
    fidx_t     bank0_mem [FACE_MAX];
    fidx_t     bank1_mem [FACE_MAX];

    state_t            state_reg;
    in_item_t          cell_reg;
    logic [2:0]        slot_reg;
    logic [CELL_W-1:0] cells_reg;
    ptr_t              fbase_reg;
    ptr_t              pos_reg;
    logic              ready_reg;
    logic              ovf_reg;
    logic              bank_reg;
    ptr_t              width_reg;
    ptr_t              lo_reg;
    ptr_t              mid_reg;
    ptr_t              hi_reg;
    ptr_t              a_reg;
    ptr_t              b_reg;
    ptr_t              k_reg;
    ptr_t              walk_reg;
    face_rec_t         head_reg;
    out_item_t         res_reg;
    logic              m_valid_reg;
    out_item_t         m_item_reg;

    fidx_t     b0_rd0_reg, b0_rd1_reg, b1_rd0_reg, b1_rd1_reg;
    face_rec_t fm_rd0_reg, fm_rd1_reg;

    face_rec_t gen_rec;
    logic      sorting;
    fidx_t     oaddr0, oaddr1;
    fidx_t     ord0, ord1;
    logic      fm_we;
    logic      b0_we, b1_we;
    fidx_t     bw_data;
    logic      take_b;
    ptr_t      n;
    ptr_t      lo_w, lo_2w;
    ptr_t      width_dbl;
    out_item_t done_item;
    out_item_t empty_item;

    hmfd_face_gen u_face_gen (
        .cell_item (cell_reg),
        .slot      (slot_reg),
        .rec       (gen_rec)
    );

    assign n         = fbase_reg;
    assign lo_w      = lo_reg + width_reg;
    assign lo_2w     = lo_reg + (width_reg << 1);
    assign width_dbl = width_reg << 1;

    assign sorting = (state_reg == ST_MRD) || (state_reg == ST_MKEY) || (state_reg == ST_MCMP);
    assign oaddr0  = sorting ? a_reg[FACE_W-1:0] : walk_reg[FACE_W-1:0];
    assign oaddr1  = b_reg[FACE_W-1:0];
    assign ord0    = bank_reg ? b1_rd0_reg : b0_rd0_reg;
    assign ord1    = bank_reg ? b1_rd1_reg : b0_rd1_reg;

    // merge decision: take from the right run when the left is used up or it sorts first
    always_comb begin
        logic before_b;
        before_b = {key_word(fm_rd1_reg.key), ord1} < {key_word(fm_rd0_reg.key), ord0};
        take_b   = (a_reg >= mid_reg) || ((b_reg < hi_reg) && before_b);
    end

    assign fm_we   = (state_reg == ST_LOAD);
    assign b0_we   = ((state_reg == ST_FILL) && (k_reg < n)) ||
                     ((state_reg == ST_MCMP) && bank_reg);
    assign b1_we   = (state_reg == ST_MCMP) && !bank_reg;
    assign bw_data = (state_reg == ST_FILL) ? k_reg[FACE_W-1:0] : (take_b ? ord1 : ord0);

    always_comb begin
        done_item                = '0;
        done_item.face_p0        = head_reg.wind[0];
        done_item.face_p1        = head_reg.wind[1];
        done_item.face_p2        = head_reg.wind[2];
        done_item.face_p3        = head_reg.wind[3];
        done_item.on_boundary    = (walk_reg == pos_reg + ptr_t'(1));
        done_item.face_valid     = 1'b1;
        done_item.final_face     = (walk_reg >= n);
        done_item.store_overflow = ovf_reg;
        empty_item                = '0;
        empty_item.store_overflow = ovf_reg;
    end

    always_ff @(posedge aclk) begin
        if (fm_we) begin
            face_mem[FACE_W'(fbase_reg + ptr_t'(slot_reg))] <= gen_rec;
        end
        fm_rd0_reg <= face_mem[ord0];
        fm_rd1_reg <= face_mem[ord1];
    end

    always_ff @(posedge aclk) begin
        if (b0_we) begin
            bank0_mem[k_reg[FACE_W-1:0]] <= bw_data;
        end
        b0_rd0_reg <= bank0_mem[oaddr0];
        b0_rd1_reg <= bank0_mem[oaddr1];
    end

    always_ff @(posedge aclk) begin
        if (b1_we) begin
            bank1_mem[k_reg[FACE_W-1:0]] <= bw_data;
        end
        b1_rd0_reg <= bank1_mem[oaddr0];
        b1_rd1_reg <= bank1_mem[oaddr1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cells_reg   <= '0;
            fbase_reg   <= '0;
            pos_reg     <= '0;
            ready_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
            bank_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // in ST_OUT the output register is handled by that state alone
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cell_reg <= s_item;
                        slot_reg <= '0;
                        unique case (cmd_e'(s_item.command))
                            CMD_LOAD: begin
                                ready_reg <= 1'b0;
                                pos_reg   <= '0;
                                if (cells_reg >= CELL_W'(MAX_CELLS)) begin
                                    ovf_reg <= 1'b1;
                                end else begin
                                    state_reg <= ST_LOAD;
                                end
                            end
                            CMD_READ: begin
                                k_reg <= '0;
                                state_reg <= ready_reg ? ST_WSTART : ST_FILL;
                            end
                            CMD_CLEAR: begin
                                cells_reg <= '0;
                                fbase_reg <= '0;
                                pos_reg   <= '0;
                                ready_reg <= 1'b0;
                                ovf_reg   <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_LOAD: begin
                    slot_reg <= slot_reg + 3'd1;
                    if (slot_reg == 3'(FACES_PER_CELL - 1)) begin
                        cells_reg <= cells_reg + CELL_W'(1);
                        fbase_reg <= fbase_reg + ptr_t'(FACES_PER_CELL);
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FILL: begin
                    if (k_reg >= n) begin
                        width_reg <= ptr_t'(1);
                        lo_reg    <= '0;
                        bank_reg  <= 1'b0;
                        if (ptr_t'(1) >= n) begin
                            ready_reg <= 1'b1;
                            pos_reg   <= '0;
                            state_reg <= ST_WSTART;
                        end else begin
                            state_reg <= ST_MSTART;
                        end
                    end else begin
                        k_reg <= k_reg + ptr_t'(1);
                    end
                end
                ST_MSTART: begin
                    if (lo_reg >= n) begin
                        // pass done, result now sits in the other bank
                        bank_reg <= !bank_reg;
                        lo_reg   <= '0;
                        width_reg <= width_dbl;
                        if (width_dbl >= n) begin
                            ready_reg <= 1'b1;
                            pos_reg   <= '0;
                            state_reg <= ST_WSTART;
                        end
                    end else begin
                        mid_reg   <= (lo_w > n) ? n : lo_w;
                        hi_reg    <= (lo_2w > n) ? n : lo_2w;
                        a_reg     <= lo_reg;
                        b_reg     <= (lo_w > n) ? n : lo_w;
                        k_reg     <= lo_reg;
                        state_reg <= ST_MRD;
                    end
                end
                ST_MRD: begin
                    if (k_reg >= hi_reg) begin
                        lo_reg    <= hi_reg;
                        state_reg <= ST_MSTART;
                    end else begin
                        state_reg <= ST_MKEY;
                    end
                end
                ST_MKEY: begin
                    state_reg <= ST_MCMP;
                end
                ST_MCMP: begin
                    k_reg <= k_reg + ptr_t'(1);
                    if (take_b) begin
                        b_reg <= b_reg + ptr_t'(1);
                    end else begin
                        a_reg <= a_reg + ptr_t'(1);
                    end
                    state_reg <= ST_MRD;
                end
                ST_WSTART: begin
                    if (pos_reg >= n) begin
                        res_reg   <= empty_item;
                        state_reg <= ST_OUT;
                    end else begin
                        walk_reg  <= pos_reg;
                        state_reg <= ST_WORD;
                    end
                end
                ST_WORD: begin
                    state_reg <= ST_WFACE;
                end
                ST_WFACE: begin
                    state_reg <= ST_WHEAD;
                end
                ST_WHEAD: begin
                    head_reg  <= fm_rd0_reg;
                    walk_reg  <= pos_reg + ptr_t'(1);
                    state_reg <= ST_WNEXT;
                end
                ST_WNEXT: begin
                    if (walk_reg >= n) begin
                        res_reg   <= done_item;
                        pos_reg   <= walk_reg;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_WNFACE;
                    end
                end
                ST_WNFACE: begin
                    state_reg <= ST_WNCMP;
                end
                ST_WNCMP: begin
                    // same key means another copy of the face
                    if (fm_rd0_reg.key == head_reg.key) begin
                        walk_reg  <= walk_reg + ptr_t'(1);
                        state_reg <= ST_WNEXT;
                    end else begin
                        res_reg   <= done_item;
                        pos_reg   <= walk_reg;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_item_reg  <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ----- rtl/hmfd_checker.sv -----
// port-level checker for the hex mesh face dedup block, bound to the top level
// depends on hmfd_pkg and hex_mesh_face_dedup_top_assert.svh
`include "hex_mesh_face_dedup_top_assert.svh"

module hmfd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input hmfd_pkg::in_item_t  s_item,
    input logic                m_valid,
    input logic                m_ready,
    input hmfd_pkg::out_item_t m_item
);
    import hmfd_pkg::*;

    logic empty_fields_zero;

    assign empty_fields_zero = (m_item.face_p0 == '0) && (m_item.face_p1 == '0) &&
                               (m_item.face_p2 == '0) && (m_item.face_p3 == '0) &&
                               !m_item.on_boundary && !m_item.final_face;

    // no result survives reset
    `HMFD_ASSERT_NXT_ALWAYS(a_reset_clears_out, !aresetn, !m_valid)

    // a stalled result holds
    `HMFD_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_item))

    // an empty read carries nothing but the overflow flag
    `HMFD_ASSERT_IMP(a_empty_read, m_valid && !m_item.face_valid, empty_fields_zero)

    // a clear transfer leaves the block ready again in the next cycle
    `HMFD_ASSERT_NXT(a_clear_busy_free, s_valid && s_ready && s_item.command == CMD_CLEAR, s_ready)

endmodule

bind hex_mesh_face_dedup_top hmfd_checker u_hmfd_checker (.*);
